// ===== hw/rtl/pnmhp_pkg.sv =====
// Shared constants, character codes and the classified-character type for the PNM header parser.
package pnmhp_pkg;

  // Field widths
  localparam int VALUE_WIDTH = 16;
  localparam int COUNT_WIDTH = 20;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Formats with no max grey field
  localparam logic [VALUE_WIDTH-1:0] MAGIC_PLAIN_BITMAP = VALUE_WIDTH'(1);
  localparam logic [VALUE_WIDTH-1:0] MAGIC_RAW_BITMAP   = VALUE_WIDTH'(4);

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_DIGIT = 2'd1,
    KIND_DELIM = 2'd2
  } char_kind_t;

  // One character after classification
  typedef struct packed {
    char_kind_t  kind;
    logic        opens_comment;
    logic        closes_comment;
    logic [3:0]  digit;
    logic        sof;
    logic        eof;
  } char_class_t;

endpackage

// ===== hw/rtl/pnmhp_char_if.sv =====
// Character request channel: valid/ready handshake with one file byte and its framing flags.
interface pnmhp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       start_of_file;
  logic       end_of_file;

  modport source (output valid, output char_code, output start_of_file, output end_of_file,
                  input ready);
  modport sink   (input valid, input char_code, input start_of_file, input end_of_file,
                  output ready);
endinterface

// ===== hw/rtl/pnmhp_header_if.sv =====
// Header result channel: valid/ready handshake carrying the parsed header fields.
interface pnmhp_header_if;
  logic                                  valid;
  logic                                  ready;
  logic [pnmhp_pkg::VALUE_WIDTH-1:0]     magic;
  logic [pnmhp_pkg::VALUE_WIDTH-1:0]     image_width;
  logic [pnmhp_pkg::VALUE_WIDTH-1:0]     image_height;
  logic [pnmhp_pkg::VALUE_WIDTH-1:0]     max_grey;
  logic [pnmhp_pkg::COUNT_WIDTH-1:0]     header_length;
  logic                                  complete;

  modport source (output valid, output magic, output image_width, output image_height,
                  output max_grey, output header_length, output complete, input ready);
  modport sink   (input valid, input magic, input image_width, input image_height,
                  input max_grey, input header_length, input complete, output ready);
endinterface

// ===== hw/rtl/pnmhp_front.sv =====
// Front end: accepts character requests and classifies each byte for the back end.
module pnmhp_front (
  pnmhp_char_if.sink              chars,
  output logic                    push_valid,
  output pnmhp_pkg::char_class_t  push_data,
  input  logic                    push_ready
);

  // Handshake passes straight to the queue
  assign push_valid  = chars.valid;
  assign chars.ready = push_ready;

  // Byte classification
  always_comb begin
    push_data                = '0;
    push_data.sof            = chars.start_of_file;
    push_data.eof            = chars.end_of_file;
    push_data.kind           = pnmhp_pkg::KIND_OTHER;
    push_data.opens_comment  = (chars.char_code == pnmhp_pkg::CHAR_HASH);
    push_data.closes_comment = (chars.char_code == pnmhp_pkg::CHAR_LF) ||
                               (chars.char_code == pnmhp_pkg::CHAR_TAB);
    push_data.digit          = 4'(chars.char_code - pnmhp_pkg::CHAR_ZERO);
    if ((chars.char_code == pnmhp_pkg::CHAR_HASH) || (chars.char_code == pnmhp_pkg::CHAR_TAB) ||
        (chars.char_code == pnmhp_pkg::CHAR_SPACE) || (chars.char_code == pnmhp_pkg::CHAR_CR) ||
        (chars.char_code == pnmhp_pkg::CHAR_LF)) begin
      push_data.kind = pnmhp_pkg::KIND_DELIM;
    end else if ((chars.char_code >= pnmhp_pkg::CHAR_ZERO) &&
                 (chars.char_code <= pnmhp_pkg::CHAR_NINE)) begin
      push_data.kind = pnmhp_pkg::KIND_DIGIT;
    end
  end

endmodule

// ===== hw/rtl/pnmhp_queue.sv =====
// Short FIFO of classified characters between the front and back ends.
module pnmhp_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push_valid,
  input  pnmhp_pkg::char_class_t  push_data,
  output logic                    push_ready,
  output logic                    pop_valid,
  output pnmhp_pkg::char_class_t  pop_data,
  input  logic                    pop_ready
);

  pnmhp_pkg::char_class_t               entries [pnmhp_pkg::QUEUE_DEPTH];
  logic [pnmhp_pkg::QUEUE_AW-1:0]       wr_ptr;
  logic [pnmhp_pkg::QUEUE_AW-1:0]       rd_ptr;
  logic [pnmhp_pkg::QUEUE_CW-1:0]       count;
  logic                                 do_push;
  logic                                 do_pop;

  localparam logic [pnmhp_pkg::QUEUE_AW-1:0] LAST_PTR =
    pnmhp_pkg::QUEUE_AW'(pnmhp_pkg::QUEUE_DEPTH - 1);
  localparam logic [pnmhp_pkg::QUEUE_CW-1:0] FULL_COUNT =
    pnmhp_pkg::QUEUE_CW'(pnmhp_pkg::QUEUE_DEPTH);

  assign push_ready = (count != FULL_COUNT);
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/pnmhp_back.sv =====
// Back end: header state update per character and the registered result stage.
module pnmhp_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    pop_valid,
  input  pnmhp_pkg::char_class_t  pop_data,
  output logic                    pop_ready,
  pnmhp_header_if.source          header
);

  localparam int VW = pnmhp_pkg::VALUE_WIDTH;
  localparam int CW = pnmhp_pkg::COUNT_WIDTH;

  // Parser state
  logic [VW-1:0] magic, width, height, grey, accum;
  logic          in_comment, header_filled, finished;
  logic [CW-1:0] char_count;

  // State seen by this character (cleared on start of file)
  logic [VW-1:0] cur_magic, cur_width, cur_height, cur_grey, cur_accum;
  logic          cur_in_comment, cur_filled, cur_finished;
  logic [CW-1:0] cur_count;

  logic [VW-1:0] magic_next, width_next, height_next, grey_next, accum_next;
  logic          in_comment_next, header_filled_next, finished_next;
  logic [CW-1:0] char_count_next;

  logic          emit, emit_complete, counted, step;
  logic [VW+3:0] accum_prod;

  // Output register
  logic          out_valid;
  logic [VW-1:0] out_magic, out_width, out_height, out_grey;
  logic [CW-1:0] out_length;
  logic          out_complete;

  assign pop_ready = !out_valid || header.ready;
  assign step      = pop_valid && pop_ready;

  always_comb begin
    cur_magic      = pop_data.sof ? '0 : magic;
    cur_width      = pop_data.sof ? '0 : width;
    cur_height     = pop_data.sof ? '0 : height;
    cur_grey       = pop_data.sof ? '0 : grey;
    cur_accum      = pop_data.sof ? '0 : accum;
    cur_in_comment = pop_data.sof ? 1'b0 : in_comment;
    cur_filled     = pop_data.sof ? 1'b0 : header_filled;
    cur_finished   = pop_data.sof ? 1'b0 : finished;
    cur_count      = pop_data.sof ? '0 : char_count;
  end

  // Decimal accumulate: accum * 10 + digit
  assign accum_prod = ({4'b0, cur_accum} << 3) + ({4'b0, cur_accum} << 1) +
                      (VW+4)'(pop_data.digit);

  // Per-character update
  always_comb begin
    magic_next         = cur_magic;
    width_next         = cur_width;
    height_next        = cur_height;
    grey_next          = cur_grey;
    accum_next         = cur_accum;
    in_comment_next    = cur_in_comment;
    header_filled_next = cur_filled;
    finished_next      = cur_finished;
    char_count_next    = cur_count;
    emit               = 1'b0;
    emit_complete      = 1'b0;
    counted            = 1'b0;
    if (!cur_finished) begin
      counted = 1'b1;
      case (pop_data.kind) inside
        pnmhp_pkg::KIND_DELIM: begin
          // a delimiter ends the number; outside a comment, a nonzero number goes into the next empty field
          if (!cur_in_comment && (cur_accum != '0)) begin
            if (cur_magic == '0) begin
              magic_next = cur_accum;
            end else if (cur_width == '0) begin
              width_next = cur_accum;
            end else if (cur_height == '0) begin
              height_next        = cur_accum;
              header_filled_next = (cur_magic == pnmhp_pkg::MAGIC_PLAIN_BITMAP) ||
                                   (cur_magic == pnmhp_pkg::MAGIC_RAW_BITMAP);
            end else if (cur_grey == '0) begin
              grey_next          = cur_accum;
              header_filled_next = (cur_magic > pnmhp_pkg::MAGIC_PLAIN_BITMAP) &&
                                   (cur_magic != pnmhp_pkg::MAGIC_RAW_BITMAP);
            end
          end
          if (pop_data.closes_comment) begin
            in_comment_next = 1'b0;
          end else if (pop_data.opens_comment) begin
            in_comment_next = 1'b1;
          end
          accum_next = '0;
        end
        pnmhp_pkg::KIND_DIGIT, pnmhp_pkg::KIND_OTHER: begin
          if (!cur_in_comment) begin
            if (cur_filled) begin
              // first data character: header done
              finished_next = 1'b1;
              emit          = 1'b1;
              emit_complete = 1'b1;
              counted       = 1'b0;
            end else if (pop_data.kind == pnmhp_pkg::KIND_DIGIT) begin
              accum_next = (accum_prod > (VW+4)'({VW{1'b1}})) ? {VW{1'b1}} : accum_prod[VW-1:0];
            end
          end
        end
        default: ;
      endcase
      if (counted) begin
        if (cur_count != {CW{1'b1}}) begin
          char_count_next = cur_count + 1'b1;
        end
        // file ended before the header finished
        if (pop_data.eof) begin
          finished_next = 1'b1;
          emit          = 1'b1;
        end
      end
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      magic         <= '0;
      width         <= '0;
      height        <= '0;
      grey          <= '0;
      accum         <= '0;
      in_comment    <= 1'b0;
      header_filled <= 1'b0;
      finished      <= 1'b0;
      char_count    <= '0;
    end else if (step) begin
      magic         <= magic_next;
      width         <= width_next;
      height        <= height_next;
      grey          <= grey_next;
      accum         <= accum_next;
      in_comment    <= in_comment_next;
      header_filled <= header_filled_next;
      finished      <= finished_next;
      char_count    <= char_count_next;
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && emit) begin
      out_valid <= 1'b1;
    end else if (header.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_magic    <= magic_next;
      out_width    <= width_next;
      out_height   <= height_next;
      out_grey     <= grey_next;
      out_length   <= char_count_next;
      out_complete <= emit_complete;
    end
  end

  assign header.valid         = out_valid;
  assign header.magic         = out_magic;
  assign header.image_width   = out_width;
  assign header.image_height  = out_height;
  assign header.max_grey      = out_grey;
  assign header.header_length = out_length;
  assign header.complete      = out_complete;

endmodule

// ===== hw/rtl/pnm_header_parser_unit.sv =====
// Top level of the PNM header parser: front end, character queue and back end.
// Takes one file byte per request and sustains one byte per cycle while no result is stalled;
// a header result passes through the character queue and then the back end's state update
// into the result register. The back end's per-character state update sets the rate. One
// result per file: complete=1 on the first data character after a full header, or
// complete=0 when end_of_file arrives first. Requests after the result are absorbed with no
// result until start_of_file. A stalled result holds the back end, and the two-entry queue
// lets the byte stream keep flowing until the queue fills and ready drops.
module pnm_header_parser_unit (
  input  logic           clk,
  input  logic           rst,
  pnmhp_char_if.sink     chars,
  pnmhp_header_if.source header
);

  logic                   push_valid, push_ready, pop_valid, pop_ready;
  pnmhp_pkg::char_class_t push_data, pop_data;

  pnmhp_front u_front (
    .chars      (chars),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  pnmhp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  pnmhp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .header    (header)
  );

endmodule

// ===== hw/rtl/pnmhp_checker.sv =====
// Port-level checks for the PNM header parser, bound to the top level.
module pnmhp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [pnmhp_pkg::VALUE_WIDTH-1:0] magic,
  input logic [pnmhp_pkg::VALUE_WIDTH-1:0] image_width,
  input logic [pnmhp_pkg::VALUE_WIDTH-1:0] image_height,
  input logic [pnmhp_pkg::VALUE_WIDTH-1:0] max_grey,
  input logic [pnmhp_pkg::COUNT_WIDTH-1:0] header_length,
  input logic                              complete
);

  // A finished header has all of magic, width and height
  a_complete_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && complete) |-> (magic != '0 && image_width != '0 && image_height != '0))
    else $error("complete header with an empty field");

  // Bitmap formats carry no max grey, the others must
  a_grey_by_format: assert property (@(posedge clk) disable iff (rst)
    (out_valid && complete) |->
      (((magic == pnmhp_pkg::MAGIC_PLAIN_BITMAP) || (magic == pnmhp_pkg::MAGIC_RAW_BITMAP))
        ? (max_grey == '0) : (max_grey != '0)))
    else $error("max grey does not match the format");

  // Every result covers at least one character
  a_length_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (header_length != '0))
    else $error("result with zero header length");

  // Nothing is reported right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result keeps its fields
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(magic) && $stable(image_width) && $stable(image_height) &&
       $stable(max_grey) && $stable(header_length) && $stable(complete)))
    else $error("stalled result changed");

endmodule

bind pnm_header_parser_unit pnmhp_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (header.valid),
  .out_ready     (header.ready),
  .magic         (header.magic),
  .image_width   (header.image_width),
  .image_height  (header.image_height),
  .max_grey      (header.max_grey),
  .header_length (header.header_length),
  .complete      (header.complete)
);

// ===== verif/pnm_header_parser_unit_checker.sv =====
// Checker for the PNM header parser: watches both channels, predicts headers, compares fields.
`timescale 1ns / 1ps

module pnm_header_parser_unit_checker (
  input  logic    clk,
  input  logic    rst,
  pnmhp_char_if   chars,
  pnmhp_header_if header,
  output int      fail_count,
  output int      pending_headers
);

  typedef struct packed {
    logic [pnmhp_pkg::VALUE_WIDTH-1:0] magic;
    logic [pnmhp_pkg::VALUE_WIDTH-1:0] image_width;
    logic [pnmhp_pkg::VALUE_WIDTH-1:0] image_height;
    logic [pnmhp_pkg::VALUE_WIDTH-1:0] max_grey;
    logic [pnmhp_pkg::COUNT_WIDTH-1:0] header_length;
    logic                              complete;
  } header_rec_t;

  header_rec_t expected_headers[$];

  // Parser state as the block should hold it
  logic [pnmhp_pkg::VALUE_WIDTH-1:0] magic_v, width_v, height_v, grey_v, accum_v;
  logic [pnmhp_pkg::COUNT_WIDTH-1:0] count_v;
  bit                                in_comment_v, filled_v, done_v;

  initial begin
    fail_count      = 0;
    pending_headers = 0;
  end

  task automatic clear_parser();
    magic_v      = '0;
    width_v      = '0;
    height_v     = '0;
    grey_v       = '0;
    accum_v      = '0;
    count_v      = '0;
    in_comment_v = 1'b0;
    filled_v     = 1'b0;
    done_v       = 1'b0;
  endtask

  task automatic record_header(input bit is_complete);
    header_rec_t rec;
    rec.magic         = magic_v;
    rec.image_width   = width_v;
    rec.image_height  = height_v;
    rec.max_grey      = grey_v;
    rec.header_length = count_v;
    rec.complete      = is_complete;
    expected_headers.push_back(rec);
    done_v = 1'b1;
  endtask

  // One character through the header state machine
  task automatic parse_char(input logic [7:0] c, input bit sof, input bit eof);
    logic [pnmhp_pkg::VALUE_WIDTH+3:0] next_value;
    if (sof) clear_parser();
    if (done_v) return;

    if (c inside {pnmhp_pkg::CHAR_HASH, pnmhp_pkg::CHAR_TAB, pnmhp_pkg::CHAR_SPACE,
                  pnmhp_pkg::CHAR_CR, pnmhp_pkg::CHAR_LF}) begin
      // a delimiter ends the number; nonzero numbers fill the next empty field
      if (!in_comment_v && accum_v != '0) begin
        if (magic_v == '0) begin
          magic_v = accum_v;
        end else if (width_v == '0) begin
          width_v = accum_v;
        end else if (height_v == '0) begin
          height_v = accum_v;
          filled_v = (magic_v == pnmhp_pkg::MAGIC_PLAIN_BITMAP ||
                      magic_v == pnmhp_pkg::MAGIC_RAW_BITMAP);
        end else if (grey_v == '0) begin
          grey_v   = accum_v;
          filled_v = (magic_v > pnmhp_pkg::MAGIC_PLAIN_BITMAP &&
                      magic_v != pnmhp_pkg::MAGIC_RAW_BITMAP);
        end
      end
      if (c == pnmhp_pkg::CHAR_LF || c == pnmhp_pkg::CHAR_TAB) in_comment_v = 1'b0;
      else if (c == pnmhp_pkg::CHAR_HASH) in_comment_v = 1'b1;
      accum_v = '0;
    end else if (!in_comment_v) begin
      if (filled_v) begin
        // first data character: header done, this char not counted
        record_header(1'b1);
        return;
      end
      if (c >= pnmhp_pkg::CHAR_ZERO && c <= pnmhp_pkg::CHAR_NINE) begin
        next_value = (pnmhp_pkg::VALUE_WIDTH+4)'(accum_v) * 10 +
                     (pnmhp_pkg::VALUE_WIDTH+4)'(c - pnmhp_pkg::CHAR_ZERO);
        if (next_value[pnmhp_pkg::VALUE_WIDTH+3:pnmhp_pkg::VALUE_WIDTH] != '0) accum_v = '1;
        else accum_v = next_value[pnmhp_pkg::VALUE_WIDTH-1:0];
      end
    end

    if (count_v != '1) count_v = count_v + 1'b1;
    if (eof) record_header(1'b0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    header_rec_t want;
    if (rst) begin
      clear_parser();
      expected_headers.delete();
    end else begin
      if (chars.valid && chars.ready)
        parse_char(chars.char_code, chars.start_of_file, chars.end_of_file);

      if (header.valid && header.ready) begin
        if (expected_headers.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected header: expected none, actual magic=%0d w=%0d h=%0d",
                   $time, header.magic, header.image_width, header.image_height);
          $display("%0t:   grey=%0d len=%0d complete=%0b", $time, header.max_grey,
                   header.header_length, header.complete);
        end else begin
          want = expected_headers.pop_front();
          check_field("magic", 32'(want.magic), 32'(header.magic));
          check_field("image_width", 32'(want.image_width), 32'(header.image_width));
          check_field("image_height", 32'(want.image_height), 32'(header.image_height));
          check_field("max_grey", 32'(want.max_grey), 32'(header.max_grey));
          check_field("header_length", 32'(want.header_length), 32'(header.header_length));
          check_field("complete", 32'(want.complete), 32'(header.complete));
        end
      end
    end
    pending_headers = expected_headers.size();
  end

endmodule

// ===== verif/pnm_header_parser_unit_test.sv =====
// Testbench top for the PNM header parser: clock, reset, file stimulus, idling and verdict.
`timescale 1ns / 1ps

module pnm_header_parser_unit_test;

  localparam int RANDOM_ITEMS       = 1400;
  localparam int QUIET_TAIL         = 150;
  localparam int STALL_LIMIT        = 2000;
  localparam int PRESSURE_CYCLES    = 300;
  localparam int PRESSURE_AFTER     = 20;
  localparam int TAIL_COMMENT_CHARS = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pnmhp_char_if   chars_ch ();
  pnmhp_header_if header_ch ();

  int fail_count;
  int pending_headers;
  int items_sent    = 0;
  int results_seen  = 0;
  int quiet_cycles  = 0;
  int gap_odds      = 0;
  bit pressure_done = 1'b0;

  logic [7:0] text_q[$];

  pnm_header_parser_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_ch),
    .header (header_ch)
  );

  pnm_header_parser_unit_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .chars           (chars_ch),
    .header          (header_ch),
    .fail_count      (fail_count),
    .pending_headers (pending_headers)
  );

  always #4 clk = ~clk;

  // Watchdog on handshake activity; also counts delivered headers
  always @(posedge clk) begin
    if (!rst) begin
      if (header_ch.valid && header_ch.ready) results_seen++;
      if ((chars_ch.valid && chars_ch.ready) || (header_ch.valid && header_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog: no request accepted for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, plus one long hold-off
  initial begin
    header_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (!pressure_done && results_seen >= PRESSURE_AFTER) begin
        header_ch.ready = 1'b0;
        repeat (PRESSURE_CYCLES - 1) @(negedge clk);
        pressure_done = 1'b1;
      end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
        header_ch.ready = 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end else begin
        header_ch.ready = 1'b1;
      end
    end
  end

  // Offer one character; returns at the falling edge after it is taken
  task automatic send_char(input logic [7:0] c, input bit sof, input bit eof);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      chars_ch.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    chars_ch.valid         = 1'b1;
    chars_ch.char_code     = c;
    chars_ch.start_of_file = sof;
    chars_ch.end_of_file   = eof;
    @(posedge clk);
    while (!chars_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input bit with_sof, input bit with_eof);
    for (int i = 0; i < text_q.size(); i++)
      send_char(text_q[i], with_sof && i == 0, with_eof && i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] data_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c inside {pnmhp_pkg::CHAR_HASH, pnmhp_pkg::CHAR_TAB, pnmhp_pkg::CHAR_SPACE,
                     pnmhp_pkg::CHAR_CR, pnmhp_pkg::CHAR_LF});
    return c;
  endfunction

  function automatic longint unsigned pick_value();
    case ($urandom_range(0, 11))
      0:       return 0;
      1:       return 65535;
      2:       return 65536 + $urandom_range(0, 100000);
      3:       return {$urandom(), $urandom()};
      4:       return $urandom_range(1, 9);
      5:       return $urandom_range(1000, 65535);
      default: return $urandom_range(1, 999);
    endcase
  endfunction

  // Decimal digits, sometimes with a leading zero or a stray letter inside
  task automatic push_number(input longint unsigned v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 5) == 0) text_q.push_back(pnmhp_pkg::CHAR_ZERO);
    for (int i = 0; i < s.len(); i++) begin
      text_q.push_back(s[i]);
      if ($urandom_range(0, 9) == 0) text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
    end
  endtask

  // Whitespace run, sometimes with a comment holding random text
  task automatic push_gap();
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 3))
        0: text_q.push_back(pnmhp_pkg::CHAR_SPACE);
        1: text_q.push_back(pnmhp_pkg::CHAR_TAB);
        2: text_q.push_back(pnmhp_pkg::CHAR_CR);
        default: text_q.push_back(pnmhp_pkg::CHAR_LF);
      endcase
    end
    if ($urandom_range(0, 4) == 0) begin
      text_q.push_back(pnmhp_pkg::CHAR_HASH);
      repeat ($urandom_range(0, 6)) begin
        case ($urandom_range(0, 4))
          0: text_q.push_back(8'($urandom_range(pnmhp_pkg::CHAR_ZERO, pnmhp_pkg::CHAR_NINE)));
          1: text_q.push_back(pnmhp_pkg::CHAR_SPACE);
          2: text_q.push_back(pnmhp_pkg::CHAR_CR);
          3: text_q.push_back(pnmhp_pkg::CHAR_HASH);
          default: text_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      text_q.push_back($urandom_range(0, 1) ? pnmhp_pkg::CHAR_LF : pnmhp_pkg::CHAR_TAB);
    end
  endtask

  initial begin
    int              target;
    int              kind;
    int              cut;
    longint unsigned magic_sel;

    chars_ch.valid         = 1'b0;
    chars_ch.char_code     = '0;
    chars_ch.start_of_file = 1'b0;
    chars_ch.end_of_file   = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: P1 ends at height, last char is the data char
    push_str("P1 2 3 x");
    send_text(1'b1, 1'b1);
    // P4 with digits in a comment, a zero number, high data byte, a trailing char
    push_str("P4#7\n9");
    text_q.push_back(pnmhp_pkg::CHAR_CR);
    push_str("0 9\t");
    text_q.push_back(8'hFF);
    push_str("Z");
    send_text(1'b1, 1'b1);
    // one-char file with both flags
    text_q.push_back(pnmhp_pkg::CHAR_NINE);
    send_text(1'b1, 1'b1);
    // saturating magic, file ends early
    push_str("P99999 ");
    send_text(1'b1, 1'b1);

    // Random files, mostly well formed
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if (items_sent > target - QUIET_TAIL) begin
        gap_odds = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: gap_odds = 0;
          1: gap_odds = 3;
          2: gap_odds = 6;
          default: gap_odds = 12;
        endcase
      end

      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        // raw noise with random framing
        repeat ($urandom_range(1, 8))
          send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                    $urandom_range(0, 7) == 0);
      end else begin
        if ($urandom_range(0, 4) == 0) push_gap();
        if ($urandom_range(0, 9) != 0) push_str("P");
        case ($urandom_range(0, 7))
          6:       magic_sel = $urandom_range(0, 9);
          7:       magic_sel = pick_value();
          default: magic_sel = $urandom_range(1, 6);
        endcase
        push_number(magic_sel);
        push_gap();
        push_number(pick_value());
        push_gap();
        push_number(pick_value());
        if (!(magic_sel inside {1, 4}) || $urandom_range(0, 3) == 0) begin
          push_gap();
          push_number(pick_value());
        end
        push_gap();
        text_q.push_back(data_byte());
        repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom_range(0, 255)));

        if (kind == 1) begin
          // truncated file
          cut = $urandom_range(1, text_q.size());
          while (text_q.size() > cut) void'(text_q.pop_back());
          send_text(1'b1, 1'b1);
        end else begin
          send_text(1'b1, kind != 2);
        end

        // chars after the result are ignored until the next start
        if ($urandom_range(0, 5) == 0)
          repeat ($urandom_range(1, 4))
            send_char(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 1));
      end
    end

    // Header with a run of comment text before the data character
    gap_odds = 0;
    push_str("P5 3 2 255 #");
    send_text(1'b1, 1'b0);
    repeat (TAIL_COMMENT_CHARS) send_char(8'($urandom_range(8'h41, 8'h7A)), 1'b0, 1'b0);
    send_char(pnmhp_pkg::CHAR_LF, 1'b0, 1'b0);
    send_char(8'h44, 1'b0, 1'b1);
    chars_ch.valid = 1'b0;

    // Drain and verdict
    wait (pending_headers == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_headers == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/pnmhp_pkg.sv
hw/rtl/pnmhp_char_if.sv
hw/rtl/pnmhp_header_if.sv
hw/rtl/pnmhp_front.sv
hw/rtl/pnmhp_queue.sv
hw/rtl/pnmhp_back.sv
hw/rtl/pnm_header_parser_unit.sv
hw/rtl/pnmhp_checker.sv
verif/pnm_header_parser_unit_checker.sv
verif/pnm_header_parser_unit_test.sv
